// ===== src/dmc_pkg.sv =====
// Shared types and constants of the depth-first maze carver.
// Depends on nothing; every other file imports it.
package dmc_pkg;

  // Grid limits.
  localparam int unsigned MaxCells = 1024;
  localparam int unsigned MaxSide  = 32;
  localparam int unsigned CellW    = 10;
  localparam int unsigned CountW   = 11;
  localparam int unsigned SideW    = 6;
  localparam int unsigned RandW    = 16;

  // Cell store entry: {mark, walls}.
  localparam int unsigned EntryW = 6;

  // Request types.
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_STEP  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Event kinds of a result beat.
  localparam logic [2:0] EV_CARVED  = 3'd0;
  localparam logic [2:0] EV_BACK    = 3'd1;
  localparam logic [2:0] EV_FINISH  = 3'd2;
  localparam logic [2:0] EV_READ    = 3'd3;
  localparam logic [2:0] EV_STARTED = 3'd4;

  // Directions, also the wall bit numbers.
  localparam logic [1:0] DIR_EAST  = 2'd0;
  localparam logic [1:0] DIR_WEST  = 2'd1;
  localparam logic [1:0] DIR_NORTH = 2'd2;
  localparam logic [1:0] DIR_SOUTH = 2'd3;

  // Cell marks.
  localparam logic [1:0] MARK_FREE  = 2'd0;
  localparam logic [1:0] MARK_STACK = 2'd1;
  localparam logic [1:0] MARK_DONE  = 2'd2;

  localparam logic [3:0] ALL_WALLS = 4'hF;

  // Configuration register indexes.
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // Remainder unit handshake.
  typedef struct packed {
    logic             start;
    logic [RandW-1:0] dividend;
    logic [SideW-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             busy;
    logic [SideW-1:0] rem;
  } mod_rsp_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_QRD,
    S_QWAIT,
    S_FRD,
    S_FWAIT,
    S_COL_GO,
    S_COL_WAIT,
    S_NB,
    S_NB_CHK,
    S_PICK_GO,
    S_PICK_WAIT,
    S_CUR_RD,
    S_CUR_WR,
    S_NXT_RD,
    S_NXT_WR,
    S_BT_RD,
    S_BT_WR,
    S_POP_RD,
    S_POP_WAIT,
    S_EMIT
  } state_e;

endpackage

// ===== src/dmc_mod_unit.sv =====
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on dmc_pkg for widths and the request and response structs.
module dmc_mod_unit
  import dmc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mod_req_t req_i,
  output mod_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(RandW);

  logic             busy_q, busy_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [RandW-1:0] div_q, div_d;
  logic [SideW-1:0] dsr_q, dsr_d;
  logic [SideW-1:0] rem_q, rem_d;
  logic [SideW:0]   shifted;
  logic [SideW:0]   diff;

  // One shift, compare and subtract step per cycle.
  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    div_d   = div_q;
    dsr_d   = dsr_q;
    rem_d   = rem_q;
    shifted = {rem_q, div_q[RandW-1]};
    diff    = shifted - {1'b0, dsr_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      div_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      if (shifted >= {1'b0, dsr_q}) begin
        rem_d = diff[SideW-1:0];
      end else begin
        rem_d = shifted[SideW-1:0];
      end
      div_d = {div_q[RandW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(RandW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      div_q  <= '0;
      dsr_q  <= '0;
      rem_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      div_q  <= div_d;
      dsr_q  <= dsr_d;
      rem_q  <= rem_d;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== src/dmc_ram.sv =====
// Single-port synchronous RAM with registered read data.
// Depends on dmc_pkg only through the common import.
module dmc_ram
  import dmc_pkg::*;
#(
  parameter int unsigned Width = EntryW,
  parameter int unsigned Depth = MaxCells
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // One access per cycle: a write, or a read whose data is registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

// ===== src/dfs_maze_carver_unit.sv =====
// Top level of the depth-first maze carver: sequencer, cell store, path stack.
// Depends on dmc_pkg, dmc_ram and dmc_mod_unit.
//
//  Channel   Signals                                  Direction
//  request   in_valid_i / in_stall_o + req fields     in
//  result    out_valid_o / out_stall_i + ev fields    out
//  config    cfg_wr_en_i, cfg_idx_i, cfg_wdata_i      in
//
// A read outside the grid skips the cell store read. The column, and the pick
// when a free neighbour exists, each hold the serial remainder unit, and each
// present neighbour adds a cell store read. A start sweeps all 1024 entries,
// one a cycle. After reset the same sweep runs with the request side stalled.
// A waiting result beat sits in the output register while the next request runs.
module dfs_maze_carver_unit
  import dmc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        req_type_i,
  input  logic [RandW-1:0]  random_value_i,
  input  logic [CellW-1:0]  query_cell_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        event_kind_o,
  output logic [CellW-1:0]  from_cell_o,
  output logic [CellW-1:0]  to_cell_o,
  output logic [1:0]        carve_direction_o,
  output logic [3:0]        wall_bits_o,
  output logic [CountW-1:0] visited_total_o,
  input  logic              cfg_wr_en_i,
  input  logic              cfg_idx_i,
  input  logic [SideW-1:0]  cfg_wdata_i
);

  localparam logic [CellW-1:0]  LastCell = CellW'(MaxCells - 1);
  localparam logic [CountW-1:0] CellsMax = CountW'(MaxCells);

  state_e state_q, state_d;

  logic [SideW-1:0]  cfg_w_q, cfg_h_q;
  logic [SideW-1:0]  sat_w, sat_h;
  logic [CountW-1:0] cell_total;
  logic [2*SideW-1:0] prod;

  logic [RandW-1:0]  rnd_q;
  logic [CellW-1:0]  query_q;
  logic              is_start_q;
  logic [CellW-1:0]  clr_q;
  logic [CellW-1:0]  cur_q;
  logic [CountW-1:0] depth_q, visit_q;
  logic [SideW-1:0]  col_q;
  logic [1:0]        k_q;
  logic [CellW-1:0]  cand_q [4];
  logic [1:0]        cdir_q [4];
  logic [2:0]        cnt_q;
  logic [CellW-1:0]  nxt_q;
  logic [1:0]        dir_q;
  logic [3:0]        cwalls_q;

  logic [2:0]        res_kind_q;
  logic [CellW-1:0]  res_from_q, res_to_q;
  logic [1:0]        res_dir_q;
  logic [3:0]        res_walls_q;

  logic              out_valid_q;
  logic [2:0]        out_kind_q;
  logic [CellW-1:0]  out_from_q, out_to_q;
  logic [1:0]        out_dir_q;
  logic [3:0]        out_walls_q;
  logic [CountW-1:0] out_visit_q;

  logic              accept, emit_load;

  // Cell store and path stack ports.
  logic              cm_re, cm_we;
  logic [CellW-1:0]  cm_addr;
  logic [EntryW-1:0] cm_wdata, cm_rdata;
  logic              st_re, st_we;
  logic [CellW-1:0]  st_addr, st_wdata, st_rdata;

  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  // Neighbour under test.
  logic [CountW-1:0] cur_ext, w_ext, nb_addr_w;
  logic              nb_ok;
  logic [1:0]        nb_dir;
  logic [SideW:0]    col_inc;
  logic [CountW-1:0] depth_dec;

  assign accept    = in_valid_i && !in_stall_o;
  assign emit_load = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);
  assign depth_dec = depth_q - 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= SideW'(16);
      cfg_h_q <= SideW'(16);
    end else if (cfg_wr_en_i) begin
      case (cfg_idx_i)
        CFG_WIDTH:  cfg_w_q <= cfg_wdata_i;
        CFG_HEIGHT: cfg_h_q <= cfg_wdata_i;
        default:    cfg_w_q <= cfg_w_q;
      endcase
    end
  end

  // Saturated sides and clamped cell count.
  always_comb begin
    if (cfg_w_q < SideW'(2)) begin
      sat_w = SideW'(2);
    end else if (cfg_w_q > SideW'(MaxSide)) begin
      sat_w = SideW'(MaxSide);
    end else begin
      sat_w = cfg_w_q;
    end
    if (cfg_h_q < SideW'(2)) begin
      sat_h = SideW'(2);
    end else if (cfg_h_q > SideW'(MaxSide)) begin
      sat_h = SideW'(MaxSide);
    end else begin
      sat_h = cfg_h_q;
    end
    prod = sat_w * sat_h;
    if (prod > (2*SideW)'(MaxCells)) begin
      cell_total = CellsMax;
    end else begin
      cell_total = prod[CountW-1:0];
    end
  end

  // Neighbour address and presence, in the order north, south, east, west.
  always_comb begin
    cur_ext = {1'b0, cur_q};
    w_ext   = CountW'(sat_w);
    col_inc = {1'b0, col_q} + 1'b1;
    case (k_q)
      2'd0: begin
        nb_addr_w = cur_ext - w_ext;
        nb_ok     = (cur_ext >= w_ext) && (nb_addr_w < cell_total);
        nb_dir    = DIR_NORTH;
      end
      2'd1: begin
        nb_addr_w = cur_ext + w_ext;
        nb_ok     = nb_addr_w < cell_total;
        nb_dir    = DIR_SOUTH;
      end
      2'd2: begin
        nb_addr_w = cur_ext + 1'b1;
        nb_ok     = (col_inc < {1'b0, sat_w}) && (nb_addr_w < cell_total);
        nb_dir    = DIR_EAST;
      end
      default: begin
        nb_addr_w = cur_ext - 1'b1;
        nb_ok     = (col_q != '0) && (nb_addr_w < cell_total);
        nb_dir    = DIR_WEST;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == LastCell) begin
          state_d = is_start_q ? S_EMIT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (req_type_i)
            REQ_START: state_d = S_CLEAR;
            REQ_READ:  state_d = ({1'b0, query_cell_i} < cell_total) ? S_QRD : S_EMIT;
            REQ_STEP: begin
              if (visit_q >= cell_total || depth_q == '0) begin
                state_d = S_FRD;
              end else begin
                state_d = S_COL_GO;
              end
            end
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_QRD:       state_d = S_QWAIT;
      S_QWAIT:     state_d = S_EMIT;
      S_FRD:       state_d = S_FWAIT;
      S_FWAIT:     state_d = S_EMIT;
      S_COL_GO:    state_d = S_COL_WAIT;
      S_COL_WAIT:  state_d = mod_rsp.busy ? S_COL_WAIT : S_NB;
      S_NB: begin
        if (nb_ok) begin
          state_d = S_NB_CHK;
        end else if (k_q == 2'd3) begin
          state_d = S_PICK_GO;
        end
      end
      S_NB_CHK:    state_d = (k_q == 2'd3) ? S_PICK_GO : S_NB;
      S_PICK_GO:   state_d = (cnt_q == '0) ? S_BT_RD : S_PICK_WAIT;
      S_PICK_WAIT: state_d = mod_rsp.busy ? S_PICK_WAIT : S_CUR_RD;
      S_CUR_RD:    state_d = S_CUR_WR;
      S_CUR_WR:    state_d = S_NXT_RD;
      S_NXT_RD:    state_d = S_NXT_WR;
      S_NXT_WR:    state_d = S_EMIT;
      S_BT_RD:     state_d = S_BT_WR;
      S_BT_WR:     state_d = (depth_dec != '0) ? S_POP_RD : S_EMIT;
      S_POP_RD:    state_d = S_POP_WAIT;
      S_POP_WAIT:  state_d = S_EMIT;
      S_EMIT:      state_d = emit_load ? S_IDLE : S_EMIT;
      default:     state_d = S_IDLE;
    endcase
  end

  // Memory ports, remainder unit requests and request stall.
  always_comb begin
    cm_re    = 1'b0;
    cm_we    = 1'b0;
    cm_addr  = cur_q;
    cm_wdata = {MARK_FREE, ALL_WALLS};
    st_re    = 1'b0;
    st_we    = 1'b0;
    st_addr  = depth_q[CellW-1:0];
    st_wdata = nxt_q;
    mod_req  = '{start: 1'b0, dividend: RandW'(cur_q), divisor: sat_w};
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_CLEAR: begin
        cm_we   = 1'b1;
        cm_addr = clr_q;
        if (is_start_q && clr_q == '0) begin
          cm_wdata = {MARK_STACK, ALL_WALLS};
        end
        if (is_start_q && clr_q == LastCell) begin
          st_we    = 1'b1;
          st_addr  = '0;
          st_wdata = '0;
        end
      end
      S_QRD: begin
        cm_re   = 1'b1;
        cm_addr = query_q;
      end
      S_FRD, S_CUR_RD, S_BT_RD: begin
        cm_re = 1'b1;
      end
      S_COL_GO: begin
        mod_req.start = 1'b1;
      end
      S_NB: begin
        cm_re   = nb_ok;
        cm_addr = nb_addr_w[CellW-1:0];
      end
      S_PICK_GO: begin
        mod_req = '{start: (cnt_q != '0), dividend: rnd_q, divisor: SideW'(cnt_q)};
      end
      S_CUR_WR: begin
        cm_we    = 1'b1;
        cm_wdata = {cm_rdata[5:4], cm_rdata[3:0] & ~(4'b0001 << dir_q)};
      end
      S_NXT_RD: begin
        cm_re   = 1'b1;
        cm_addr = nxt_q;
      end
      S_NXT_WR: begin
        cm_we    = 1'b1;
        cm_addr  = nxt_q;
        cm_wdata = {MARK_STACK, cm_rdata[3:0] & ~(4'b0001 << (dir_q ^ 2'b01))};
        st_we    = (depth_q < CellsMax);
      end
      S_BT_WR: begin
        cm_we    = 1'b1;
        cm_wdata = {MARK_DONE, cm_rdata[3:0]};
      end
      S_POP_RD: begin
        st_re   = 1'b1;
        st_addr = depth_dec[CellW-1:0];
      end
      default: begin
        cm_re = 1'b0;
      end
    endcase
  end

  // Walk state, candidates and the pending result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      rnd_q       <= '0;
      query_q     <= '0;
      is_start_q  <= 1'b0;
      clr_q       <= '0;
      cur_q       <= '0;
      depth_q     <= '0;
      visit_q     <= '0;
      col_q       <= '0;
      k_q         <= '0;
      cnt_q       <= '0;
      nxt_q       <= '0;
      dir_q       <= '0;
      cwalls_q    <= '0;
      res_kind_q  <= EV_FINISH;
      res_from_q  <= '0;
      res_to_q    <= '0;
      res_dir_q   <= '0;
      res_walls_q <= '0;
      for (int i = 0; i < 4; i++) begin
        cand_q[i] <= '0;
        cdir_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == LastCell && is_start_q) begin
            cur_q       <= '0;
            depth_q     <= CountW'(1);
            visit_q     <= CountW'(1);
            res_kind_q  <= EV_STARTED;
            res_from_q  <= '0;
            res_to_q    <= '0;
            res_dir_q   <= DIR_EAST;
            res_walls_q <= ALL_WALLS;
          end
        end
        S_IDLE: begin
          if (accept) begin
            rnd_q       <= random_value_i;
            query_q     <= query_cell_i;
            is_start_q  <= 1'b1;
            clr_q       <= '0;
            k_q         <= '0;
            cnt_q       <= '0;
            res_kind_q  <= EV_READ;
            res_from_q  <= query_cell_i;
            res_to_q    <= cur_q;
            res_dir_q   <= DIR_EAST;
            res_walls_q <= '0;
          end
        end
        S_QWAIT: begin
          res_walls_q <= cm_rdata[3:0];
        end
        S_FWAIT: begin
          res_kind_q  <= EV_FINISH;
          res_from_q  <= cur_q;
          res_to_q    <= cur_q;
          res_walls_q <= cm_rdata[3:0];
        end
        S_COL_WAIT: begin
          col_q <= mod_rsp.rem;
        end
        S_NB: begin
          if (!nb_ok) begin
            k_q <= k_q + 1'b1;
          end
        end
        S_NB_CHK: begin
          k_q <= k_q + 1'b1;
          if (cm_rdata[5:4] == MARK_FREE) begin
            cand_q[cnt_q[1:0]] <= nb_addr_w[CellW-1:0];
            cdir_q[cnt_q[1:0]] <= nb_dir;
            cnt_q              <= cnt_q + 1'b1;
          end
        end
        S_PICK_WAIT: begin
          nxt_q <= cand_q[mod_rsp.rem[1:0]];
          dir_q <= cdir_q[mod_rsp.rem[1:0]];
        end
        S_CUR_WR: begin
          cwalls_q <= cm_rdata[3:0] & ~(4'b0001 << dir_q);
        end
        S_NXT_WR: begin
          if (depth_q < CellsMax) begin
            depth_q <= depth_q + 1'b1;
          end
          if (visit_q < CellsMax) begin
            visit_q <= visit_q + 1'b1;
          end
          cur_q       <= nxt_q;
          res_kind_q  <= EV_CARVED;
          res_from_q  <= cur_q;
          res_to_q    <= nxt_q;
          res_dir_q   <= dir_q;
          res_walls_q <= cwalls_q;
        end
        S_BT_WR: begin
          depth_q     <= depth_dec;
          res_kind_q  <= EV_BACK;
          res_from_q  <= cur_q;
          res_to_q    <= cur_q;
          res_dir_q   <= DIR_EAST;
          res_walls_q <= cm_rdata[3:0];
        end
        S_POP_WAIT: begin
          cur_q    <= st_rdata;
          res_to_q <= st_rdata;
        end
        default: begin
          cur_q <= cur_q;
        end
      endcase
    end
  end

  // Output register: holds one result beat while the next request runs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_kind_q  <= '0;
      out_from_q  <= '0;
      out_to_q    <= '0;
      out_dir_q   <= '0;
      out_walls_q <= '0;
      out_visit_q <= '0;
    end else if (emit_load) begin
      out_valid_q <= 1'b1;
      out_kind_q  <= res_kind_q;
      out_from_q  <= res_from_q;
      out_to_q    <= res_to_q;
      out_dir_q   <= res_dir_q;
      out_walls_q <= res_walls_q;
      out_visit_q <= visit_q;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign event_kind_o      = out_kind_q;
  assign from_cell_o       = out_from_q;
  assign to_cell_o         = out_to_q;
  assign carve_direction_o = out_dir_q;
  assign wall_bits_o       = out_walls_q;
  assign visited_total_o   = out_visit_q;

  // Marks and walls of every cell.
  dmc_ram #(
    .Width(EntryW),
    .Depth(MaxCells)
  ) u_cell_ram (
    .clk_i  (clk_i),
    .re_i   (cm_re),
    .we_i   (cm_we),
    .addr_i (cm_addr),
    .wdata_i(cm_wdata),
    .rdata_o(cm_rdata)
  );

  // Path of the walker.
  dmc_ram #(
    .Width(CellW),
    .Depth(MaxCells)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .re_i   (st_re),
    .we_i   (st_we),
    .addr_i (st_addr),
    .wdata_i(st_wdata),
    .rdata_o(st_rdata)
  );

  // Shared remainder unit: column of the walker and the random pick.
  dmc_mod_unit u_mod (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mod_req),
    .rsp_o (mod_rsp)
  );

endmodule
